// ===== hw/rtl/pfcr_pkg.sv =====
// ----------------------------------------------------------------------------
// pfcr_pkg
// Shared types and constants of the pretrigger fault capture ring.
// ----------------------------------------------------------------------------
package pfcr_pkg;

    localparam int DEPTH      = 4096;
    localparam int FRAME_BITS = 64;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = 13;
    localparam int WIN_W      = 14;
    localparam int IDX_W      = 16;
    localparam int CFG_W      = 13;

    localparam logic [CNT_W-1:0] PRE_RESET   = CNT_W'(100);
    localparam logic [CNT_W-1:0] POST_RESET  = CNT_W'(100);
    localparam logic [CNT_W-1:0] FILL_MAX    = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] AFTER_MAX   = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_PUSH    = 2'd0,
        ACT_TRIGGER = 2'd1,
        ACT_READ    = 2'd2,
        ACT_NOP     = 2'd3
    } t_action;

    typedef enum logic {
        CFG_PRE  = 1'b0,
        CFG_POST = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_action     action;
        logic [63:0] frame_data;
        logic [15:0] read_index;
    } t_in;

    typedef struct packed {
        logic [63:0] read_data;
        logic        frozen_flag;
        logic        triggered_flag;
        logic [12:0] valid_frames;
        logic [11:0] window_start;
        logic [13:0] window_frames;
    } t_out;

endpackage

// ===== hw/rtl/pretrigger_fault_capture_ring_top.sv =====
// ----------------------------------------------------------------------------
// pretrigger_fault_capture_ring_top
// Capture ring with trigger latch, post-trigger freeze and slot read-back.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_stall    i_in_data  (t_in)
//   out       output     o_out_valid / i_out_stall  o_out_data (t_out)
//   cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// One beat per cycle while the output is not stalled; each input beat yields one output beat in the next cycle.
// The store is one single-port RAM: a push writes it, a read uses its
// registered read port, so one access per beat sets the rate.
// Reset is synchronous; the store keeps its contents, all pointers clear.
// The input stalls only while an output beat waits under i_out_stall.
// ----------------------------------------------------------------------------
module pretrigger_fault_capture_ring_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  pfcr_pkg::t_in          i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output pfcr_pkg::t_out         o_out_data,
    input  logic                   i_cfg_we,
    input  pfcr_pkg::t_cfg_index   i_cfg_index,
    input  logic [pfcr_pkg::CFG_W-1:0] i_cfg_data
);
    import pfcr_pkg::*;

    logic [FRAME_BITS-1:0] r_store [DEPTH];
    logic [FRAME_BITS-1:0] r_rd_data;
    logic                  r_rd_sel;

    logic [ADDR_W-1:0] r_write_slot,   n_write_slot;
    logic [CNT_W-1:0]  r_filled,       n_filled;
    logic              r_armed,        n_armed;
    logic [ADDR_W-1:0] r_trig_slot,    n_trig_slot;
    logic [CNT_W-1:0]  r_after,        n_after;
    logic              r_locked,       n_locked;
    logic [CNT_W-1:0]  r_pre_frames;
    logic [CNT_W-1:0]  r_post_frames;

    logic              r_out_valid;
    logic              r_frozen;
    logic              r_triggered;
    logic [CNT_W-1:0]  r_valid_frames;
    logic [11:0]       r_window_start;
    logic [WIN_W-1:0]  r_window_frames;

    logic              accept;
    logic              do_push;
    logic [ADDR_W-1:0] n_window_start;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;
    assign do_push    = accept & (i_in_data.action == ACT_PUSH) & ~r_locked;

    always_comb begin
        n_write_slot = r_write_slot;
        n_filled     = r_filled;
        n_armed      = r_armed;
        n_trig_slot  = r_trig_slot;
        n_after      = r_after;
        n_locked     = r_locked;
        case (i_in_data.action)
            ACT_PUSH: begin
                if (!r_locked) begin
                    n_write_slot = r_write_slot + ADDR_W'(1);
                    if (r_filled < FILL_MAX) begin
                        n_filled = r_filled + CNT_W'(1);
                    end
                    if (r_armed) begin
                        if (r_after != AFTER_MAX) begin
                            n_after = r_after + CNT_W'(1);
                        end
                        if (n_after >= r_post_frames) begin
                            n_locked = 1'b1;
                        end
                    end
                end
            end
            ACT_TRIGGER: begin
                if (!r_armed) begin
                    n_armed     = 1'b1;
                    n_trig_slot = r_write_slot;
                    n_after     = '0;
                end
            end
            default: begin
            end
        endcase
        n_window_start = n_trig_slot - r_pre_frames[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_write_slot] <= i_in_data.frame_data[FRAME_BITS-1:0];
        end
        if (accept && (i_in_data.action == ACT_READ)) begin
            r_rd_data <= r_store[i_in_data.read_index[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_slot    <= '0;
            r_filled        <= '0;
            r_armed         <= 1'b0;
            r_trig_slot     <= '0;
            r_after         <= '0;
            r_locked        <= 1'b0;
            r_pre_frames    <= PRE_RESET;
            r_post_frames   <= POST_RESET;
            r_out_valid     <= 1'b0;
            r_rd_sel        <= 1'b0;
            r_frozen        <= 1'b0;
            r_triggered     <= 1'b0;
            r_valid_frames  <= '0;
            r_window_start  <= '0;
            r_window_frames <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PRE:  r_pre_frames  <= i_cfg_data;
                    CFG_POST: r_post_frames <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_write_slot    <= n_write_slot;
                r_filled        <= n_filled;
                r_armed         <= n_armed;
                r_trig_slot     <= n_trig_slot;
                r_after         <= n_after;
                r_locked        <= n_locked;
                r_out_valid     <= 1'b1;
                r_rd_sel        <= (i_in_data.action == ACT_READ);
                r_frozen        <= n_locked;
                r_triggered     <= n_armed;
                r_valid_frames  <= n_filled;
                r_window_start  <= 12'(n_window_start);
                r_window_frames <= WIN_W'(r_pre_frames) + WIN_W'(r_post_frames);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_out_data                = '0;
        o_out_data.read_data      = r_rd_sel ? 64'(r_rd_data) : 64'd0;
        o_out_data.frozen_flag    = r_frozen;
        o_out_data.triggered_flag = r_triggered;
        o_out_data.valid_frames   = r_valid_frames;
        o_out_data.window_start   = r_window_start;
        o_out_data.window_frames  = r_window_frames;
    end

    assign o_out_valid = r_out_valid;

endmodule
